[hw/rtl/hsl_to_rgb_convert_defines.svh]
// assertion macros for the hsl to rgb converter
`ifndef HSL_TO_RGB_CONVERT_DEFINES_SVH
`define HSL_TO_RGB_CONVERT_DEFINES_SVH

`ifndef SYNTHESIS
// checked at every rising edge outside reset
`define HSL_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsl to rgb assertion failed");
// checked at every rising edge, reset included
`define HSL_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hsl to rgb assertion failed");
`else
`define HSL_ASSERT(label, clk, rst, prop)
`define HSL_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hw/rtl/hsl2rgb_pkg.sv]
`default_nettype none

package hsl2rgb_pkg;

  // hue resolution, fraction of a full turn
  localparam int unsigned HUE_BITS = 16;
  // components in units of 1/65025 fit in 16 bits
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned PROD_W   = COMP_W + HUE_BITS;
  localparam int unsigned H6_W     = HUE_BITS + 3;
  localparam int unsigned FULL     = 255;
  localparam int unsigned HALF_MAX = 127;

  typedef enum logic [2:0] {
    SX_RED_GRN_UP = 3'd0,
    SX_GRN_RED_DN = 3'd1,
    SX_GRN_BLU_UP = 3'd2,
    SX_BLU_GRN_DN = 3'd3,
    SX_BLU_RED_UP = 3'd4,
    SX_RED_BLU_DN = 3'd5
  } sext_t;

  typedef struct packed {
    logic [15:0] hue;
    logic        hue_undefined;
    logic [7:0]  saturation;
    logic [7:0]  lightness;
  } pix_hsl_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_rgb_t;

  typedef struct packed {
    logic [COMP_W-1:0]   v;
    logic [COMP_W-1:0]   y;
    logic [COMP_W-1:0]   span;
    sext_t               sext;
    logic [HUE_BITS-1:0] frac;
    logic                gray;
    logic [7:0]          light;
  } prep_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
    logic              gray;
    logic [7:0]        light;
  } comp_t;

  // floor(c / 255) for c up to 65025: reciprocal estimate, then one correction
  function automatic logic [7:0] div255(input logic [COMP_W-1:0] c);
    logic [24:0] m;
    logic [8:0]  q;
    logic [16:0] r;
    m = 25'(c) + 25'({c, 8'b0});
    q = m[24:16];
    r = 17'(c) - 17'({q, 8'b0}) + 17'(q);
    if (r >= 17'(FULL)) begin
      q = q + 9'd1;
    end
    return q[7:0];
  endfunction

endpackage

`default_nettype wire

[hw/rtl/hsl2rgb_prep.sv]
`default_nettype none
`include "hsl_to_rgb_convert_defines.svh"

module hsl2rgb_prep (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  up_valid,
  output logic                       up_stall,
  input  wire hsl2rgb_pkg::pix_hsl_t up_pix,
  output logic                       dn_valid,
  input  wire logic                  dn_stall,
  output hsl2rgb_pkg::prep_t         dn_data
);
  import hsl2rgb_pkg::*;

  logic [HUE_BITS-1:0] hue_m;
  logic [H6_W-1:0]     h6;
  logic [15:0]         ls;
  logic [15:0]         l255;
  logic [15:0]         s255;
  logic [16:0]         v17;
  logic [16:0]         twol;
  logic [16:0]         y17;
  logic [16:0]         span17;
  prep_t               dn_data_next;

  always_comb begin
    hue_m = HUE_BITS'(up_pix.hue);
    h6    = H6_W'({hue_m, 2'b00}) + H6_W'({hue_m, 1'b0});
    ls    = 16'(up_pix.lightness) * 16'(up_pix.saturation);
    l255  = 16'(up_pix.lightness) * 16'(FULL);
    s255  = 16'(up_pix.saturation) * 16'(FULL);
    // v = l*255 + l*s below half, l*255 + s*255 - l*s above
    if (up_pix.lightness <= 8'(HALF_MAX)) begin
      v17 = 17'(l255) + 17'(ls);
    end else begin
      v17 = 17'(l255) + 17'(s255) - 17'(ls);
    end
    twol   = 17'(up_pix.lightness) * 17'(2 * FULL);
    y17    = twol - v17;
    span17 = v17 - y17;

    dn_data_next.v     = v17[COMP_W-1:0];
    dn_data_next.y     = y17[COMP_W-1:0];
    dn_data_next.span  = span17[COMP_W-1:0];
    dn_data_next.sext  = sext_t'(h6[H6_W-1:HUE_BITS]);
    dn_data_next.frac  = h6[HUE_BITS-1:0];
    dn_data_next.gray  = up_pix.hue_undefined | (up_pix.saturation == 8'd0);
    dn_data_next.light = up_pix.lightness;
  end

  assign up_stall = dn_valid & dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

  `HSL_ASSERT(a_prep_span, clk, rst,
    dn_valid |-> 17'(dn_data.y) + 17'(dn_data.span) == 17'(dn_data.v))
  `HSL_ASSERT(a_prep_load, clk, rst, up_valid && !up_stall |=> dn_valid)
  `HSL_ASSERT(a_prep_hold, clk, rst, dn_valid && dn_stall |=> $stable(dn_data))

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_ramp.sv]
`default_nettype none
`include "hsl_to_rgb_convert_defines.svh"

module hsl2rgb_ramp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire hsl2rgb_pkg::prep_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output hsl2rgb_pkg::comp_t      dn_data
);
  import hsl2rgb_pkg::*;

  // stage 2: ramp product
  logic              s2_valid;
  logic [PROD_W-1:0] s2_prod;
  logic [COMP_W-1:0] s2_v;
  logic [COMP_W-1:0] s2_y;
  sext_t             s2_sext;
  logic              s2_gray;
  logic [7:0]        s2_light;
  logic              s2_hold;
  logic              s3_hold;

  logic [COMP_W-1:0] ramp;
  logic              ramp_rem;
  logic [COMP_W-1:0] x_up;
  logic [COMP_W-1:0] z_dn;
  comp_t             dn_data_next;

  assign s3_hold  = dn_valid & dn_stall;
  assign s2_hold  = s2_valid & s3_hold;
  assign up_stall = s2_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (!s2_hold) begin
      s2_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s2_hold && up_valid) begin
      s2_prod  <= PROD_W'(up_data.span) * PROD_W'(up_data.frac);
      s2_v     <= up_data.v;
      s2_y     <= up_data.y;
      s2_sext  <= up_data.sext;
      s2_gray  <= up_data.gray;
      s2_light <= up_data.light;
    end
  end

  // falling ramp rounds its scaled product up, rising ramp down
  always_comb begin
    ramp     = s2_prod[PROD_W-1:HUE_BITS];
    ramp_rem = |s2_prod[HUE_BITS-1:0];
    x_up     = s2_y + ramp;
    z_dn     = s2_v - ramp - COMP_W'(ramp_rem);

    dn_data_next.gray  = s2_gray;
    dn_data_next.light = s2_light;
    unique case (s2_sext)
      SX_RED_GRN_UP: begin
        dn_data_next.red = s2_v; dn_data_next.green = x_up; dn_data_next.blue = s2_y;
      end
      SX_GRN_RED_DN: begin
        dn_data_next.red = z_dn; dn_data_next.green = s2_v; dn_data_next.blue = s2_y;
      end
      SX_GRN_BLU_UP: begin
        dn_data_next.red = s2_y; dn_data_next.green = s2_v; dn_data_next.blue = x_up;
      end
      SX_BLU_GRN_DN: begin
        dn_data_next.red = s2_y; dn_data_next.green = z_dn; dn_data_next.blue = s2_v;
      end
      SX_BLU_RED_UP: begin
        dn_data_next.red = x_up; dn_data_next.green = s2_y; dn_data_next.blue = s2_v;
      end
      SX_RED_BLU_DN: begin
        dn_data_next.red = s2_v; dn_data_next.green = s2_y; dn_data_next.blue = z_dn;
      end
      default: begin
        dn_data_next.red = s2_v; dn_data_next.green = x_up; dn_data_next.blue = s2_y;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!s3_hold) begin
      dn_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!s3_hold && s2_valid) begin
      dn_data <= dn_data_next;
    end
  end

  `HSL_ASSERT(a_ramp_order, clk, rst, s2_valid |-> s2_y <= s2_v)
  `HSL_ASSERT(a_ramp_advance, clk, rst, s2_valid && !s2_hold |=> dn_valid)

endmodule

`default_nettype wire

[hw/rtl/hsl2rgb_div.sv]
`default_nettype none
`include "hsl_to_rgb_convert_defines.svh"

module hsl2rgb_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  output logic                    up_stall,
  input  wire hsl2rgb_pkg::comp_t up_data,
  output logic                    dn_valid,
  input  wire logic               dn_stall,
  output hsl2rgb_pkg::pix_rgb_t   dn_pix
);
  import hsl2rgb_pkg::*;

  pix_rgb_t dn_pix_next;

  always_comb begin
    if (up_data.gray) begin
      dn_pix_next.red   = up_data.light;
      dn_pix_next.green = up_data.light;
      dn_pix_next.blue  = up_data.light;
    end else begin
      dn_pix_next.red   = div255(up_data.red);
      dn_pix_next.green = div255(up_data.green);
      dn_pix_next.blue  = div255(up_data.blue);
    end
  end

  assign up_stall = dn_valid & dn_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (!up_stall) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!up_stall && up_valid) begin
      dn_pix <= dn_pix_next;
    end
  end

  `HSL_ASSERT(a_div_gray, clk, rst,
    up_valid && !up_stall && up_data.gray |=>
      dn_pix.red == dn_pix.green && dn_pix.green == dn_pix.blue)
  `HSL_ASSERT_ALWAYS(a_div_reset, clk, rst |=> !dn_valid)

endmodule

`default_nettype wire

[hw/rtl/hsl_to_rgb_convert.sv]
// HSL to 8-bit RGB pixel converter. Takes one pixel per clock while hsl_stall is
// low and returns one RGB pixel for each accepted pixel, in order. The four
// register stages are: max/min and sextant (one 8x8
// multiply), the ramp product (span times hue fraction, 16 x HUE_BITS), ramp and
// component select, and the divide by 255 into the output register. Each stage
// holds its beat while the one after it is stalled, so bubbles are squeezed out
// and the input stall rises only when every stage is full. A set hue_undefined
// flag or zero saturation gives gray at the lightness level.
`default_nettype none

module hsl_to_rgb_convert (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  hsl_valid,
  output logic                       hsl_stall,
  input  wire hsl2rgb_pkg::pix_hsl_t hsl,
  output logic                       rgb_valid,
  input  wire logic                  rgb_stall,
  output hsl2rgb_pkg::pix_rgb_t      rgb
);
  import hsl2rgb_pkg::*;

  logic  prep_valid;
  logic  prep_stall;
  prep_t prep_data;
  logic  comp_valid;
  logic  comp_stall;
  comp_t comp_data;

  hsl2rgb_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .up_valid (hsl_valid),
    .up_stall (hsl_stall),
    .up_pix   (hsl),
    .dn_valid (prep_valid),
    .dn_stall (prep_stall),
    .dn_data  (prep_data)
  );

  hsl2rgb_ramp u_ramp (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prep_valid),
    .up_stall (prep_stall),
    .up_data  (prep_data),
    .dn_valid (comp_valid),
    .dn_stall (comp_stall),
    .dn_data  (comp_data)
  );

  hsl2rgb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .up_valid (comp_valid),
    .up_stall (comp_stall),
    .up_data  (comp_data),
    .dn_valid (rgb_valid),
    .dn_stall (rgb_stall),
    .dn_pix   (rgb)
  );

endmodule

`default_nettype wire
